/* design/multi_car_elevator_look_scheduler_macros.svh */
// Assertion macros used by the scheduler's execute module.
`ifndef MULTI_CAR_ELEVATOR_LOOK_SCHEDULER_MACROS_SVH
`define MULTI_CAR_ELEVATOR_LOOK_SCHEDULER_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define MCELS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define MCELS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mcels_pkg.sv */
`default_nettype none

package mcels_pkg;

    localparam logic       REQ_FLOOR = 1'b0;
    localparam logic       REQ_TICK  = 1'b1;

    localparam logic       KIND_REQ  = 1'b0;
    localparam logic       KIND_TICK = 1'b1;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_UP   = 2'd1;
    localparam logic [1:0] MODE_DOWN = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] dest_floor;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [2:0] car_index;
        logic [3:0] car_floor;
        logic [1:0] car_mode;
        logic       moved;
        logic       stopped;
        logic       rejected;
        logic       any_pending;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       is_tick;
        logic       rejected;
        logic [7:0] dest;
    } t_cmd;

endpackage

`default_nettype wire

/* design/multi_car_elevator_look_scheduler.sv */
// LOOK scheduler for up to NUM_CARS elevator cars over NUM_FLOORS floors. Each
// input transaction is a floor request or a tick. A front register classifies
// it and flags an out-of-range destination, then a two-entry queue hands it
// to the execute stage, which updates the car state and loads a report
// buffer that drives the output. A request yields one report; a tick yields
// one report per car in use (the effective car count), in car order.
// The output port therefore sets the rate: requests flow at one per cycle
// while i_out_ready is high, and a tick holds back the next item until all
// of its reports are taken. The first report of an item appears at the output
// after it passes the front register, the queue and the report buffer. No
// clearing pass follows reset. The car count register is written with
// i_cfg_we; zero acts as one and values above NUM_CARS act as NUM_CARS.
`default_nettype none

module multi_car_elevator_look_scheduler
    import mcels_pkg::*;
#(
    parameter int NUM_CARS   = 2,
    parameter int NUM_FLOORS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    input  wire t_in_item   i_in_data,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output t_out_item       o_out_data,
    input  wire logic       i_out_ready
);

    logic [3:0] r_cars_in_use;
    logic       push;
    t_cmd       front_cmd;
    logic       q_ready;
    logic       q_valid;
    t_cmd       q_cmd;
    logic       pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cars_in_use <= 4'd2;
        end else if (i_cfg_we) begin
            r_cars_in_use <= i_cfg_wdata;
        end
    end

    mcels_front #(
        .NUM_FLOORS(NUM_FLOORS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_data (i_in_data),
        .o_in_ready(o_in_ready),
        .o_push    (push),
        .o_cmd     (front_cmd),
        .i_q_ready (q_ready)
    );

    mcels_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .o_ready(q_ready),
        .o_valid(q_valid),
        .o_cmd  (q_cmd),
        .i_pop  (pop)
    );

    mcels_exec #(
        .NUM_CARS  (NUM_CARS),
        .NUM_FLOORS(NUM_FLOORS)
    ) u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cars_in_use(r_cars_in_use),
        .i_q_valid    (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_ready  (i_out_ready)
    );

endmodule

`default_nettype wire

/* design/mcels_front.sv */
`default_nettype none

module mcels_front
    import mcels_pkg::*;
#(
    parameter int NUM_FLOORS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_data,
    output logic          o_in_ready,
    output logic          o_push,
    output t_cmd          o_cmd,
    input  wire logic     i_q_ready
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign o_in_ready = !r_valid || i_q_ready;
    assign o_push     = r_valid;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.is_tick  = (i_in_data.req_type == REQ_TICK);
        n_cmd.rejected = (i_in_data.req_type == REQ_FLOOR) &&
                         ({24'd0, i_in_data.dest_floor} >= 32'(NUM_FLOORS));
        n_cmd.dest     = i_in_data.dest_floor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/mcels_queue.sv */
`default_nettype none

module mcels_queue
    import mcels_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_ready,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({do_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/mcels_exec.sv */
`default_nettype none
`include "multi_car_elevator_look_scheduler_macros.svh"

module mcels_exec
    import mcels_pkg::*;
#(
    parameter int NUM_CARS   = 2,
    parameter int NUM_FLOORS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [3:0] i_cars_in_use,
    input  wire logic       i_q_valid,
    input  wire t_cmd       i_cmd,
    output logic            o_pop,
    output logic            o_out_valid,
    output t_out_item       o_out_data,
    input  wire logic       i_out_ready
);

    localparam int FW = (NUM_FLOORS > 2) ? $clog2(NUM_FLOORS) : 1;
    localparam int CW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
    localparam int NW = $clog2(NUM_CARS + 1);

    logic [FW-1:0]         r_floor [NUM_CARS];
    logic [1:0]            r_mode  [NUM_CARS];
    logic [NUM_FLOORS-1:0] r_up    [NUM_CARS];
    logic [NUM_FLOORS-1:0] r_down  [NUM_CARS];
    logic [FW-1:0]         n_floor [NUM_CARS];
    logic [1:0]            n_mode  [NUM_CARS];
    logic [NUM_FLOORS-1:0] n_up    [NUM_CARS];
    logic [NUM_FLOORS-1:0] n_down  [NUM_CARS];

    logic [FW-1:0]         r_sfloor [NUM_CARS];
    logic [1:0]            r_smode  [NUM_CARS];
    logic                  r_smoved [NUM_CARS];
    logic                  r_sstop  [NUM_CARS];
    logic                  mv       [NUM_CARS];
    logic                  st       [NUM_CARS];

    logic                  r_busy;
    logic                  r_kind;
    logic                  r_rej;
    logic                  r_pend;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_last;

    logic [NW-1:0]         act_cars;
    logic [CW-1:0]         last_car;
    logic [CW-1:0]         sel;
    logic                  found;
    logic                  pend;
    logic                  emit_done;
    logic [FW-1:0]         dest;
    logic [FW-1:0]         f;
    logic [1:0]            m;
    logic [NUM_FLOORS-1:0] u;
    logic [NUM_FLOORS-1:0] d;
    logic [FW+3:0]         floor_ext;
    logic [CW+2:0]         idx_ext;

    always_comb begin
        if (i_cars_in_use == 4'd0) begin
            act_cars = NW'(1);
        end else if ({28'd0, i_cars_in_use} > 32'(NUM_CARS)) begin
            act_cars = NW'(NUM_CARS);
        end else begin
            act_cars = i_cars_in_use[NW-1:0];
        end
        last_car = CW'(act_cars - NW'(1));
    end

    assign emit_done = i_out_ready && (r_idx == r_last);
    assign o_pop     = i_q_valid && (!r_busy || emit_done);
    assign dest      = i_cmd.dest[FW-1:0];

    always_comb begin
        sel   = '0;
        found = 1'b0;
        f     = '0;
        m     = MODE_IDLE;
        u     = '0;
        d     = '0;
        for (int c = 0; c < NUM_CARS; c++) begin
            n_floor[c] = r_floor[c];
            n_mode[c]  = r_mode[c];
            n_up[c]    = r_up[c];
            n_down[c]  = r_down[c];
            mv[c]      = 1'b0;
            st[c]      = 1'b0;
            if (c < int'(act_cars) && !found && r_mode[c] == MODE_IDLE) begin
                sel   = CW'(c);
                found = 1'b1;
            end
        end

        if (o_pop && !i_cmd.is_tick && !i_cmd.rejected) begin
            if (dest > r_floor[sel]) begin
                n_up[sel][dest] = 1'b1;
            end else if (dest < r_floor[sel]) begin
                n_down[sel][dest] = 1'b1;
            end
            if (r_mode[sel] == MODE_IDLE) begin
                if (n_up[sel] != '0) begin
                    n_mode[sel] = MODE_UP;
                end else if (n_down[sel] != '0) begin
                    n_mode[sel] = MODE_DOWN;
                end
            end
        end

        if (o_pop && i_cmd.is_tick) begin
            for (int c = 0; c < NUM_CARS; c++) begin
                if (c < int'(act_cars)) begin
                    f = r_floor[c];
                    m = r_mode[c];
                    u = r_up[c];
                    d = r_down[c];
                    if (m == MODE_IDLE) begin
                        if (u != '0) begin
                            m = MODE_UP;
                        end else if (d != '0) begin
                            m = MODE_DOWN;
                        end
                    end
                    if (m == MODE_UP) begin
                        if (u != '0 && f < FW'(NUM_FLOORS - 1)) begin
                            f     = f + FW'(1);
                            mv[c] = 1'b1;
                            if (u[f]) begin
                                u[f]  = 1'b0;
                                st[c] = 1'b1;
                            end
                        end
                        if (u == '0) begin
                            m = (d != '0) ? MODE_DOWN : MODE_IDLE;
                        end
                    end else if (m == MODE_DOWN) begin
                        if (d != '0 && f > FW'(0)) begin
                            f     = f - FW'(1);
                            mv[c] = 1'b1;
                            if (d[f]) begin
                                d[f]  = 1'b0;
                                st[c] = 1'b1;
                            end
                        end
                        if (d == '0) begin
                            m = (u != '0) ? MODE_UP : MODE_IDLE;
                        end
                    end
                    n_floor[c] = f;
                    n_mode[c]  = m;
                    n_up[c]    = u;
                    n_down[c]  = d;
                end
            end
        end

        pend = 1'b0;
        for (int c = 0; c < NUM_CARS; c++) begin
            if (c < int'(act_cars) && (n_up[c] != '0 || n_down[c] != '0)) begin
                pend = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CARS; c++) begin
                r_floor[c] <= '0;
                r_mode[c]  <= MODE_IDLE;
                r_up[c]    <= '0;
                r_down[c]  <= '0;
            end
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_last <= '0;
        end else begin
            for (int c = 0; c < NUM_CARS; c++) begin
                r_floor[c] <= n_floor[c];
                r_mode[c]  <= n_mode[c];
                r_up[c]    <= n_up[c];
                r_down[c]  <= n_down[c];
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= i_cmd.is_tick ? '0 : sel;
                r_last <= i_cmd.is_tick ? last_car : sel;
            end else if (r_busy && emit_done) begin
                r_busy <= 1'b0;
            end else if (r_busy && i_out_ready) begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int c = 0; c < NUM_CARS; c++) begin
                r_sfloor[c] <= n_floor[c];
                r_smode[c]  <= n_mode[c];
                r_smoved[c] <= mv[c];
                r_sstop[c]  <= st[c];
            end
            r_kind <= i_cmd.is_tick ? KIND_TICK : KIND_REQ;
            r_rej  <= !i_cmd.is_tick && i_cmd.rejected;
            r_pend <= pend;
        end
    end

    assign floor_ext = {4'd0, r_sfloor[r_idx]};
    assign idx_ext   = {3'd0, r_idx};

    always_comb begin
        o_out_valid            = r_busy;
        o_out_data.result_kind = r_kind;
        o_out_data.car_index   = idx_ext[2:0];
        o_out_data.car_floor   = floor_ext[3:0];
        o_out_data.car_mode    = r_smode[r_idx];
        o_out_data.moved       = r_smoved[r_idx];
        o_out_data.stopped     = r_sstop[r_idx];
        o_out_data.rejected    = r_rej;
        o_out_data.any_pending = r_pend;
        o_out_data.last        = (r_idx == r_last);
    end

    `MCELS_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, r_busy && !i_out_ready, r_busy && $stable(r_idx), "report index moved while stalled")
    `MCELS_ASSERT_IMP(a_idx_bound, i_clk, i_rst_n, r_busy, r_idx <= r_last, "report index passed the last car")
    `MCELS_ASSERT_IMP(a_idle_empty, i_clk, i_rst_n, r_mode[0] == MODE_IDLE, r_up[0] == '0 && r_down[0] == '0, "idle car holds targets")
    `MCELS_ASSERT_IMP(a_no_self_target, i_clk, i_rst_n, 1'b1, r_up[0][r_floor[0]] == 1'b0 && r_down[0][r_floor[0]] == 1'b0, "car holds a target at its own floor")

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import mcels_pkg::*;

    localparam int NUM_CARS   = 2;
    localparam int NUM_FLOORS = 16;
    localparam int NUM_ROWS   = 24;
    localparam int NUM_PHASES = 5;
    localparam int PHASE_ITEMS = 22;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;
    logic       in_valid = 1'b0;
    t_in_item   in_data = '0;
    logic       in_ready;
    logic       out_valid;
    t_out_item  out_data;
    logic       out_ready = 1'b0;

    bit         row_typed = 1'b0;
    t_out_item  row_want = '0;

    logic [3:0]  car_floor_q [NUM_CARS];
    logic [1:0]  car_mode_q  [NUM_CARS];
    logic [15:0] up_set      [NUM_CARS];
    logic [15:0] down_set    [NUM_CARS];
    logic [3:0]  car_count_cfg = 4'd2;

    t_out_item expected_reports [$];

    int err_count = 0;
    int stall_cycles = 0;
    int items_sent = 0;
    int reports_seen = 0;
    int ticks_sent = 0;
    int rejects_seen = 0;
    int stops_seen = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    t_stim_row directed_rows [NUM_ROWS] = '{
        '{'{REQ_FLOOR, 8'd255}, 1'b1,
          '{KIND_REQ, 3'd0, 4'd0, MODE_IDLE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{REQ_FLOOR, 8'd0},   1'b1,
          '{KIND_REQ, 3'd0, 4'd0, MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{REQ_FLOOR, 8'd16},  1'b1,
          '{KIND_REQ, 3'd0, 4'd0, MODE_IDLE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{REQ_FLOOR, 8'd128}, 1'b1,
          '{KIND_REQ, 3'd0, 4'd0, MODE_IDLE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{REQ_TICK,  8'd255}, 1'b0, '0},
        '{'{REQ_FLOOR, 8'd15},  1'b1,
          '{KIND_REQ, 3'd0, 4'd0, MODE_UP, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{REQ_FLOOR, 8'd5},   1'b1,
          '{KIND_REQ, 3'd1, 4'd0, MODE_UP, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{REQ_FLOOR, 8'd0},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0},
        '{'{REQ_FLOOR, 8'd2},   1'b0, '0},
        '{'{REQ_FLOOR, 8'd12},  1'b0, '0},
        '{'{REQ_FLOOR, 8'd3},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0},
        '{'{REQ_TICK,  8'd0},   1'b0, '0}
    };

    logic [3:0] phase_car_count [NUM_PHASES] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2};
    int         phase_send_idle [NUM_PHASES] = '{0, 50, 0, 22, 22};
    int         phase_stall     [NUM_PHASES] = '{0, 0, 50, 22, 0};

    multi_car_elevator_look_scheduler #(
        .NUM_CARS   (NUM_CARS),
        .NUM_FLOORS (NUM_FLOORS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_ready (out_ready)
    );

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    function automatic int live_cars();
        int n;
        n = int'(car_count_cfg);
        if (n < 1) n = 1;
        if (n > NUM_CARS) n = NUM_CARS;
        return n;
    endfunction

    function automatic bit targets_left();
        bit pend;
        pend = 1'b0;
        for (int c = 0; c < live_cars(); c++) begin
            if (up_set[c] != 16'd0 || down_set[c] != 16'd0) pend = 1'b1;
        end
        return pend;
    endfunction

    function automatic void add_expected(t_out_item r);
        expected_reports = {expected_reports, r};
    endfunction

    function automatic void choose_direction(int c);
        if (car_mode_q[c] == MODE_IDLE) begin
            if (up_set[c] != 16'd0) car_mode_q[c] = MODE_UP;
            else if (down_set[c] != 16'd0) car_mode_q[c] = MODE_DOWN;
        end
    endfunction

    function automatic void move_one_floor(int c, output bit moved, output bit stopped);
        moved = 1'b0;
        stopped = 1'b0;
        choose_direction(c);
        if (car_mode_q[c] == MODE_UP) begin
            if (up_set[c] != 16'd0 && car_floor_q[c] < NUM_FLOORS - 1) begin
                car_floor_q[c] = car_floor_q[c] + 4'd1;
                moved = 1'b1;
                if (up_set[c][car_floor_q[c]]) begin
                    up_set[c][car_floor_q[c]] = 1'b0;
                    stopped = 1'b1;
                end
            end
            if (up_set[c] == 16'd0) car_mode_q[c] = (down_set[c] != 16'd0) ? MODE_DOWN : MODE_IDLE;
        end else if (car_mode_q[c] == MODE_DOWN) begin
            if (down_set[c] != 16'd0 && car_floor_q[c] > 4'd0) begin
                car_floor_q[c] = car_floor_q[c] - 4'd1;
                moved = 1'b1;
                if (down_set[c][car_floor_q[c]]) begin
                    down_set[c][car_floor_q[c]] = 1'b0;
                    stopped = 1'b1;
                end
            end
            if (down_set[c] == 16'd0) car_mode_q[c] = (up_set[c] != 16'd0) ? MODE_UP : MODE_IDLE;
        end
    endfunction

    function automatic t_out_item car_report(logic kind, int c, bit moved, bit stopped,
                                             bit rej, bit pend, bit last_one);
        t_out_item r;
        r.result_kind = kind;
        r.car_index   = c[2:0];
        r.car_floor   = car_floor_q[c];
        r.car_mode    = car_mode_q[c];
        r.moved       = moved;
        r.stopped     = stopped;
        r.rejected    = rej;
        r.any_pending = pend;
        r.last        = last_one;
        return r;
    endfunction

    function automatic void advance_schedule(t_in_item it);
        int  n;
        int  car;
        bit  rej;
        bit  pend;
        bit  mv [NUM_CARS];
        bit  st [NUM_CARS];
        n = live_cars();
        if (it.req_type == REQ_FLOOR) begin
            car = 0;
            for (int c = n - 1; c >= 0; c--) begin
                if (car_mode_q[c] == MODE_IDLE) car = c;
            end
            rej = (it.dest_floor >= NUM_FLOORS);
            if (!rej) begin
                if (it.dest_floor > car_floor_q[car]) up_set[car][it.dest_floor[3:0]] = 1'b1;
                else if (it.dest_floor < car_floor_q[car]) down_set[car][it.dest_floor[3:0]] = 1'b1;
                choose_direction(car);
            end
            add_expected(car_report(KIND_REQ, car, 1'b0, 1'b0, rej, targets_left(), 1'b1));
        end else begin
            for (int c = 0; c < n; c++) move_one_floor(c, mv[c], st[c]);
            pend = targets_left();
            for (int c = 0; c < n; c++) begin
                add_expected(car_report(KIND_TICK, c, mv[c], st[c], 1'b0, pend, c == n - 1));
            end
        end
    endfunction

    function automatic string show_report(t_out_item r);
        return $sformatf("kind=%0d car=%0d floor=%0d mode=%0d moved=%0d stop=%0d rej=%0d pend=%0d last=%0d",
                         r.result_kind, r.car_index, r.car_floor, r.car_mode, r.moved,
                         r.stopped, r.rejected, r.any_pending, r.last);
    endfunction

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endfunction

    function automatic void check_report(t_out_item got);
        t_out_item want;
        if (expected_reports.size() == 0) begin
            note_error($sformatf("Unexpected result transaction: %s", show_report(got)));
        end else begin
            want = expected_reports.pop_front();
            if (got.result_kind !== want.result_kind || got.car_index !== want.car_index ||
                got.car_floor !== want.car_floor || got.car_mode !== want.car_mode ||
                got.moved !== want.moved || got.stopped !== want.stopped ||
                got.rejected !== want.rejected || got.any_pending !== want.any_pending ||
                got.last !== want.last) begin
                note_error($sformatf("Mismatch at %0t\n  expected %s\n  actual   %s",
                                     $realtime, show_report(want), show_report(got)));
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((out_valid && out_ready) || (in_valid && in_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (out_valid && out_ready) begin
                reports_seen++;
                if (out_data.rejected === 1'b1) rejects_seen++;
                if (out_data.stopped === 1'b1) stops_seen++;
                check_report(out_data);
            end
            if (in_valid && in_ready) begin
                advance_schedule(in_data);
                if (row_typed) expected_reports[expected_reports.size() - 1] = row_want;
            end
        end
    end

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("[multi_car_elevator_look_scheduler] ERROR");
        $finish;
    end

    task automatic send_item(t_in_item it, bit typed, t_out_item want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid  <= 1'b1;
        in_data   <= it;
        row_typed <= typed;
        row_want  <= want;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
        if (it.req_type == REQ_TICK) ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_car_count(logic [3:0] value);
        drain_reports();
        repeat (6) @(negedge i_clk);
        cfg_we        <= 1'b1;
        cfg_wdata     <= value;
        car_count_cfg = value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        it.dest_floor = 8'($urandom_range(255));
        if ($urandom_range(99) < 45) begin
            it.req_type = REQ_TICK;
        end else begin
            it.req_type = REQ_FLOOR;
            if ($urandom_range(99) < 12) it.dest_floor = 8'($urandom_range(255, NUM_FLOORS));
            else it.dest_floor = 8'($urandom_range(NUM_FLOORS - 1));
        end
        return it;
    endfunction

    initial begin
        for (int c = 0; c < NUM_CARS; c++) begin
            car_floor_q[c] = 4'd0;
            car_mode_q[c]  = MODE_IDLE;
            up_set[c]      = 16'd0;
            down_set[c]    = 16'd0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_car_count(phase_car_count[p]);
            send_idle_pct = phase_send_idle[p];
            stall_pct     = phase_stall[p];
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == PHASE_ITEMS / 2) drain_reports();
                send_item(random_item(), 1'b0, '0);
            end
        end

        drain_reports();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d input transactions (%0d ticks) over %0d car-count settings.",
                 items_sent, ticks_sent, NUM_PHASES + 1);
        $display("Checked %0d result transactions: %0d rejections, %0d floor stops, %0d errors.",
                 reports_seen, rejects_seen, stops_seen, err_count);
        if (err_count == 0 && expected_reports.size() == 0) begin
            $display("[multi_car_elevator_look_scheduler] OK");
        end else begin
            $display("[multi_car_elevator_look_scheduler] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/mcels_pkg.sv
design/mcels_front.sv
design/mcels_queue.sv
design/mcels_exec.sv
design/multi_car_elevator_look_scheduler.sv
test/testbench.sv
